// File: rtl/core/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Types, register codes and hold-window helpers shared by the packet loss
// impairment block.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

	localparam int AddrW = 5;
	localparam int DueW  = 35;

	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_START_THR,
		REG_CONT_THR,
		REG_JITTER_BOUND,
		REG_HOLD_A_START,
		REG_HOLD_A_LEN,
		REG_HOLD_B_START,
		REG_HOLD_B_LEN
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_KEPT,
		VERDICT_VIDEO_LOST,
		VERDICT_DISCARD,
		VERDICT_AUDIO_LOST
	} verdict_t;

	localparam logic STREAM_VIDEO = 1'b0;
	localparam logic STREAM_AUDIO = 1'b1;

	typedef logic signed [DueW-1:0] due_t;

	localparam due_t LastReset = {1'b1, {(DueW-1){1'b0}}};

	typedef struct packed {
		logic        enable;
		logic [15:0] start_thr;
		logic [15:0] cont_thr;
		logic [19:0] jitter_bound;
		logic [31:0] hold_a_start;
		logic [31:0] hold_a_len;
		logic [31:0] hold_b_start;
		logic [31:0] hold_b_len;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        key;
		logic [15:0] draw;
		due_t        due;
	} item_t;

	function automatic due_t hold_once(due_t t, logic [31:0] start, logic [31:0] len);
		due_t s;
		due_t e;
		s = $signed({3'b000, start});
		e = $signed({2'b00, {1'b0, start} + {1'b0, len}});
		return (t >= s && t < e) ? e : t;
	endfunction

	function automatic due_t hold_pass(due_t t, cfg_t c);
		return hold_once(hold_once(t, c.hold_a_start, c.hold_a_len),
			c.hold_b_start, c.hold_b_len);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/plc_cfg.sv
// ----------------------------------------------------------------------------
// plc_cfg
// APB register file for the loss thresholds, jitter bound and hold windows.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [plc_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output plc_pkg::cfg_t                  cfg
);

	plc_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = plc_pkg::reg_idx_t'(paddr[plc_pkg::AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr_en) begin
			unique case (idx)
				plc_pkg::REG_ENABLE:       cfg.enable       <= pwdata[0];
				plc_pkg::REG_START_THR:    cfg.start_thr    <= pwdata[15:0];
				plc_pkg::REG_CONT_THR:     cfg.cont_thr     <= pwdata[15:0];
				plc_pkg::REG_JITTER_BOUND: cfg.jitter_bound <= pwdata[19:0];
				plc_pkg::REG_HOLD_A_START: cfg.hold_a_start <= pwdata;
				plc_pkg::REG_HOLD_A_LEN:   cfg.hold_a_len   <= pwdata;
				plc_pkg::REG_HOLD_B_START: cfg.hold_b_start <= pwdata;
				plc_pkg::REG_HOLD_B_LEN:   cfg.hold_b_len   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			plc_pkg::REG_ENABLE:       prdata = {31'd0, cfg.enable};
			plc_pkg::REG_START_THR:    prdata = {16'd0, cfg.start_thr};
			plc_pkg::REG_CONT_THR:     prdata = {16'd0, cfg.cont_thr};
			plc_pkg::REG_JITTER_BOUND: prdata = {12'd0, cfg.jitter_bound};
			plc_pkg::REG_HOLD_A_START: prdata = cfg.hold_a_start;
			plc_pkg::REG_HOLD_A_LEN:   prdata = cfg.hold_a_len;
			plc_pkg::REG_HOLD_B_START: prdata = cfg.hold_b_start;
			plc_pkg::REG_HOLD_B_LEN:   prdata = cfg.hold_b_len;
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/plc_due.sv
// ----------------------------------------------------------------------------
// plc_due
// Release time pipeline: input register, jitter clamp, then one hold pass
// per stage over both windows.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_due (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire plc_pkg::cfg_t      cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               stream_kind,
	input  wire logic [31:0]        arrival_us,
	input  wire logic               has_key_frame,
	input  wire logic [15:0]        loss_draw,
	input  wire logic signed [20:0] jitter_draw_us,
	input  wire logic               out_free,
	output logic                    item_valid,
	output plc_pkg::item_t          item
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               en_s1, en_s2, en_s3, en_s4, en_s5;
	logic               kind_s1, key_s1;
	logic [15:0]        draw_s1;
	logic [31:0]        arrival_s1;
	logic signed [20:0] jitter_s1;
	plc_pkg::item_t     item_s2, item_s3, item_s4, item_s5;
	plc_pkg::item_t     next_s2;
	logic signed [21:0] jit_w, bnd_w, jit_c;

	assign en_s5    = !v_s5 || out_free;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_comb begin
		jit_w = {jitter_s1[20], jitter_s1};
		bnd_w = $signed({2'b00, cfg.jitter_bound});
		if (jit_w > bnd_w) begin
			jit_c = bnd_w;
		end else if (jit_w < -bnd_w) begin
			jit_c = -bnd_w;
		end else begin
			jit_c = jit_w;
		end
		next_s2.kind = kind_s1;
		next_s2.key  = key_s1;
		next_s2.draw = draw_s1;
		if (cfg.enable) begin
			next_s2.due = $signed({3'b000, arrival_s1})
				+ $signed({{(plc_pkg::DueW-22){jit_c[21]}}, jit_c});
		end else begin
			next_s2.due = $signed({3'b000, arrival_s1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1    <= stream_kind;
			key_s1     <= has_key_frame;
			draw_s1    <= loss_draw;
			arrival_s1 <= arrival_us;
			jitter_s1  <= jitter_draw_us;
		end
		if (en_s2) item_s2 <= next_s2;
		if (en_s3) begin
			item_s3.kind <= item_s2.kind;
			item_s3.key  <= item_s2.key;
			item_s3.draw <= item_s2.draw;
			item_s3.due  <= cfg.enable ? plc_pkg::hold_pass(item_s2.due, cfg) : item_s2.due;
		end
		if (en_s4) begin
			item_s4.kind <= item_s3.kind;
			item_s4.key  <= item_s3.key;
			item_s4.draw <= item_s3.draw;
			item_s4.due  <= cfg.enable ? plc_pkg::hold_pass(item_s3.due, cfg) : item_s3.due;
		end
		if (en_s5) begin
			item_s5.kind <= item_s4.kind;
			item_s5.key  <= item_s4.key;
			item_s5.draw <= item_s4.draw;
			item_s5.due  <= cfg.enable ? plc_pkg::hold_pass(item_s4.due, cfg) : item_s4.due;
		end
	end

	assign item_valid = v_s5;
	assign item       = item_s5;

endmodule

`default_nettype wire

// File: rtl/core/plc_loss.sv
// ----------------------------------------------------------------------------
// plc_loss
// Two-state loss processes, key frame resync, per-stream monotone release
// and drop counters, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_loss (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire plc_pkg::cfg_t       cfg,
	input  wire logic                item_valid,
	input  wire plc_pkg::item_t      item,
	output logic                     out_free,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               verdict,
	output logic signed [33:0]       release_us,
	output logic                     resync_started,
	output logic [31:0]              video_lost_count,
	output logic [31:0]              resync_count,
	output logic [31:0]              discard_count,
	output logic [31:0]              audio_lost_count
);

	logic              video_run_q, audio_run_q, awaiting_q;
	plc_pkg::due_t     last_video_q, last_audio_q;
	logic              load;
	logic              cur_run, run_new;
	logic [15:0]       thr;
	plc_pkg::verdict_t vd;
	logic              resync;
	logic              key_clear;
	plc_pkg::due_t     last_cur, due_mono;

	assign out_free = !out_valid || !out_stall;
	assign load     = item_valid && out_free;

	always_comb begin
		cur_run   = (item.kind == plc_pkg::STREAM_AUDIO) ? audio_run_q : video_run_q;
		thr       = cur_run ? cfg.cont_thr : cfg.start_thr;
		run_new   = item.draw < thr;
		last_cur  = (item.kind == plc_pkg::STREAM_AUDIO) ? last_audio_q : last_video_q;
		due_mono  = (item.due < last_cur) ? last_cur : item.due;
		vd        = plc_pkg::VERDICT_KEPT;
		resync    = 1'b0;
		key_clear = 1'b0;
		if (cfg.enable) begin
			if (item.kind == plc_pkg::STREAM_AUDIO) begin
				if (run_new) vd = plc_pkg::VERDICT_AUDIO_LOST;
			end else if (run_new) begin
				vd     = plc_pkg::VERDICT_VIDEO_LOST;
				resync = !awaiting_q;
			end else if (awaiting_q) begin
				if (!item.key) begin
					vd = plc_pkg::VERDICT_DISCARD;
				end else begin
					key_clear = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid        <= 1'b0;
			video_run_q      <= 1'b0;
			audio_run_q      <= 1'b0;
			awaiting_q       <= 1'b0;
			last_video_q     <= plc_pkg::LastReset;
			last_audio_q     <= plc_pkg::LastReset;
			video_lost_count <= '0;
			resync_count     <= '0;
			discard_count    <= '0;
			audio_lost_count <= '0;
		end else if (load) begin
			out_valid <= 1'b1;
			if (cfg.enable) begin
				if (item.kind == plc_pkg::STREAM_AUDIO) begin
					audio_run_q <= run_new;
				end else begin
					video_run_q <= run_new;
				end
				if (resync) awaiting_q <= 1'b1;
				if (key_clear) awaiting_q <= 1'b0;
				if (resync) resync_count <= resync_count + 32'd1;
				unique case (vd)
					plc_pkg::VERDICT_VIDEO_LOST: video_lost_count <= video_lost_count + 32'd1;
					plc_pkg::VERDICT_DISCARD:    discard_count    <= discard_count + 32'd1;
					plc_pkg::VERDICT_AUDIO_LOST: audio_lost_count <= audio_lost_count + 32'd1;
					plc_pkg::VERDICT_KEPT: begin
						if (item.kind == plc_pkg::STREAM_AUDIO) begin
							last_audio_q <= due_mono;
						end else begin
							last_video_q <= due_mono;
						end
					end
					default: ;
				endcase
			end
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict        <= vd;
			resync_started <= resync;
			if (vd != plc_pkg::VERDICT_KEPT) begin
				release_us <= '0;
			end else if (cfg.enable) begin
				release_us <= due_mono[33:0];
			end else begin
				release_us <= item.due[33:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/packet_loss_impairment.sv
// ----------------------------------------------------------------------------
// packet_loss_impairment
// Two-state burst packet loss with key frame resync, clamped jitter, two
// hold windows and per-stream monotone release times.
//
//   channel   direction   handshake               payload
//   in        sink        in_valid / in_stall     stream_kind .. jitter_draw_us
//   out       source      out_valid / out_stall   verdict .. audio_lost_count
//   config    APB slave   psel/penable/pready     paddr, pwdata, prdata
//
// One item per cycle while out_stall is low; out_valid rises through six
// registers: input register, jitter clamp, three hold passes, result
// register. Loss state, resync flag and release floors update in the
// result stage. Reset clears all state; no clearing pass. A stalled output
// backs the pipeline up stage by stage before in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_loss_impairment (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [plc_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      stream_kind,
	input  wire logic [31:0]               arrival_us,
	input  wire logic                      has_key_frame,
	input  wire logic [15:0]               loss_draw,
	input  wire logic signed [20:0]        jitter_draw_us,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [1:0]                     verdict,
	output logic signed [33:0]             release_us,
	output logic                           resync_started,
	output logic [31:0]                    video_lost_count,
	output logic [31:0]                    resync_count,
	output logic [31:0]                    discard_count,
	output logic [31:0]                    audio_lost_count
);

	plc_pkg::cfg_t  cfg;
	plc_pkg::item_t item;
	logic           item_valid;
	logic           out_free;

	plc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	plc_due u_due (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.stream_kind    (stream_kind),
		.arrival_us     (arrival_us),
		.has_key_frame  (has_key_frame),
		.loss_draw      (loss_draw),
		.jitter_draw_us (jitter_draw_us),
		.out_free       (out_free),
		.item_valid     (item_valid),
		.item           (item)
	);

	plc_loss u_loss (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.item_valid       (item_valid),
		.item             (item),
		.out_free         (out_free),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.verdict          (verdict),
		.release_us       (release_us),
		.resync_started   (resync_started),
		.video_lost_count (video_lost_count),
		.resync_count     (resync_count),
		.discard_count    (discard_count),
		.audio_lost_count (audio_lost_count)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet loss impairment block. A built-in
// predictor tracks the burst loss state, key frame resync, jitter clamp,
// hold windows and per-stream release floors, and every result item is
// compared field by field in order. Directed items cover pass-through,
// loss and resync, clamping and window chaining, then randomized traffic
// runs under several register settings and stall patterns, and a last
// directed group drives release times to the top of their range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int SETS_PER_PHASE = 5;
	localparam int ITEMS_PER_SET  = 102;
	localparam int EXP_DEPTH      = 64;

	typedef struct {
		logic               kind;
		logic [31:0]        arrival;
		logic               key;
		logic [15:0]        draw;
		logic signed [20:0] jitter;
	} pkt_t;

	typedef struct {
		plc_pkg::verdict_t  verdict;
		logic signed [33:0] rel_us;
		logic               resync;
		logic [31:0]        n_vlost;
		logic [31:0]        n_resync;
		logic [31:0]        n_discard;
		logic [31:0]        n_alost;
	} pkt_out_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [plc_pkg::AddrW-1:0] paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      stream_kind = 1'b0;
	logic [31:0]               arrival_us = '0;
	logic                      has_key_frame = 1'b0;
	logic [15:0]               loss_draw = '0;
	logic signed [20:0]        jitter_draw_us = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                verdict;
	logic signed [33:0]        release_us;
	logic                      resync_started;
	logic [31:0]               video_lost_count;
	logic [31:0]               resync_count;
	logic [31:0]               discard_count;
	logic [31:0]               audio_lost_count;

	plc_pkg::cfg_t cfg_shadow = '0;
	logic          vid_burst = 1'b0;
	logic          aud_burst = 1'b0;
	logic          wait_idr = 1'b0;
	longint        floor_due [2] = '{-64'sd17179869184, -64'sd17179869184};
	logic [31:0]   tot_vlost = '0;
	logic [31:0]   tot_resync = '0;
	logic [31:0]   tot_discard = '0;
	logic [31:0]   tot_alost = '0;

	pkt_out_t    exp_q [EXP_DEPTH];
	int          exp_wr = 0;
	int          exp_rd = 0;
	int          exp_count = 0;
	pkt_out_t    want;
	pkt_t        seen;
	int          n_err = 0;
	int          n_res = 0;
	int          idle_cycles = 0;
	int          src_idle_pct = 26;
	int          snk_idle_pct = 59;
	longint      timeline_us = 100000;

	packet_loss_impairment u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= (snk_idle_pct != 0) && ($urandom_range(99) < snk_idle_pct);
	end

	task automatic report(string what, logic [63:0] got, logic [63:0] exp);
		n_err++;
		$display("mismatch %s: got 0x%0h expected 0x%0h", what, got, exp);
	endtask

	function automatic bit push_past_window(inout longint t, input logic [31:0] s,
			input logic [31:0] len);
		longint lo;
		longint hi;
		lo = longint'({32'b0, s});
		hi = lo + longint'({32'b0, len});
		if (t >= lo && t < hi) begin
			t = hi;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic pkt_out_t predict_packet(pkt_t p);
		pkt_out_t r;
		longint   due;
		longint   lim;
		longint   jit;
		bit       ha;
		bit       hb;
		int       pass;
		r.verdict = plc_pkg::VERDICT_KEPT;
		r.resync = 1'b0;
		due = longint'({32'b0, p.arrival});
		if (cfg_shadow.enable) begin
			if (p.kind == plc_pkg::STREAM_VIDEO) begin
				vid_burst = vid_burst ? (p.draw < cfg_shadow.cont_thr)
					: (p.draw < cfg_shadow.start_thr);
				if (vid_burst) begin
					r.verdict = plc_pkg::VERDICT_VIDEO_LOST;
					tot_vlost++;
					if (!wait_idr) begin
						wait_idr = 1'b1;
						tot_resync++;
						r.resync = 1'b1;
					end
				end else if (wait_idr) begin
					if (!p.key) begin
						r.verdict = plc_pkg::VERDICT_DISCARD;
						tot_discard++;
					end else begin
						wait_idr = 1'b0;
					end
				end
			end else begin
				aud_burst = aud_burst ? (p.draw < cfg_shadow.cont_thr)
					: (p.draw < cfg_shadow.start_thr);
				if (aud_burst) begin
					r.verdict = plc_pkg::VERDICT_AUDIO_LOST;
					tot_alost++;
				end
			end
			if (r.verdict == plc_pkg::VERDICT_KEPT) begin
				lim = longint'({44'b0, cfg_shadow.jitter_bound});
				jit = longint'(p.jitter);
				if (jit > lim) jit = lim;
				if (jit < -lim) jit = -lim;
				due += jit;
				for (pass = 0; pass < 3; pass++) begin
					ha = push_past_window(due, cfg_shadow.hold_a_start, cfg_shadow.hold_a_len);
					hb = push_past_window(due, cfg_shadow.hold_b_start, cfg_shadow.hold_b_len);
					if (!(ha || hb)) break;
				end
				if (due < floor_due[p.kind]) due = floor_due[p.kind];
				floor_due[p.kind] = due;
			end
		end
		r.rel_us = (r.verdict == plc_pkg::VERDICT_KEPT) ? due[33:0] : '0;
		r.n_vlost = tot_vlost;
		r.n_resync = tot_resync;
		r.n_discard = tot_discard;
		r.n_alost = tot_alost;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
			if (in_valid && !in_stall) begin
				seen.kind = stream_kind;
				seen.arrival = arrival_us;
				seen.key = has_key_frame;
				seen.draw = loss_draw;
				seen.jitter = jitter_draw_us;
				exp_q[exp_wr] = predict_packet(seen);
				exp_wr = (exp_wr + 1) % EXP_DEPTH;
				exp_count++;
			end
			if (out_valid && !out_stall) begin
				if (exp_count == 0) begin
					report($sformatf("unexpected result %0d", n_res), 64'(verdict), 64'd0);
				end else begin
					want = exp_q[exp_rd];
					exp_rd = (exp_rd + 1) % EXP_DEPTH;
					exp_count--;
					if (verdict !== want.verdict)
						report($sformatf("result %0d verdict", n_res), 64'(verdict),
							64'(want.verdict));
					if (release_us !== want.rel_us)
						report($sformatf("result %0d release_us", n_res), 64'(release_us),
							64'(want.rel_us));
					if (resync_started !== want.resync)
						report($sformatf("result %0d resync_started", n_res),
							64'(resync_started), 64'(want.resync));
					if (video_lost_count !== want.n_vlost)
						report($sformatf("result %0d video_lost_count", n_res),
							64'(video_lost_count), 64'(want.n_vlost));
					if (resync_count !== want.n_resync)
						report($sformatf("result %0d resync_count", n_res), 64'(resync_count),
							64'(want.n_resync));
					if (discard_count !== want.n_discard)
						report($sformatf("result %0d discard_count", n_res), 64'(discard_count),
							64'(want.n_discard));
					if (audio_lost_count !== want.n_alost)
						report($sformatf("result %0d audio_lost_count", n_res),
							64'(audio_lost_count), 64'(want.n_alost));
				end
				n_res++;
			end
		end
	end

	task automatic write_reg(plc_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			plc_pkg::REG_ENABLE:       cfg_shadow.enable = val[0];
			plc_pkg::REG_START_THR:    cfg_shadow.start_thr = val[15:0];
			plc_pkg::REG_CONT_THR:     cfg_shadow.cont_thr = val[15:0];
			plc_pkg::REG_JITTER_BOUND: cfg_shadow.jitter_bound = val[19:0];
			plc_pkg::REG_HOLD_A_START: cfg_shadow.hold_a_start = val;
			plc_pkg::REG_HOLD_A_LEN:   cfg_shadow.hold_a_len = val;
			plc_pkg::REG_HOLD_B_START: cfg_shadow.hold_b_start = val;
			plc_pkg::REG_HOLD_B_LEN:   cfg_shadow.hold_b_len = val;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== val)
			report($sformatf("readback of %s", idx.name()), 64'(prdata), 64'(val));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_pkt(pkt_t p);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stream_kind <= p.kind;
		arrival_us <= p.arrival;
		has_key_frame <= p.key;
		loss_draw <= p.draw;
		jitter_draw_us <= p.jitter;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (exp_count != 0) @(negedge clk);
	endtask

	function automatic pkt_t mk_pkt(logic kind, logic [31:0] arr, logic key, logic [15:0] draw,
			int jit);
		pkt_t p;
		p.kind = kind;
		p.arrival = arr;
		p.key = key;
		p.draw = draw;
		p.jitter = 21'(jit);
		return p;
	endfunction

	function automatic pkt_t next_random_pkt();
		pkt_t        p;
		int unsigned b;
		int unsigned pick;
		longint      t;
		b = 32'(cfg_shadow.jitter_bound);
		p.kind = 1'($urandom_range(1));
		p.key = ($urandom_range(3) == 0);
		pick = $urandom_range(9);
		if (pick < 7) begin
			p.draw = 16'($urandom_range(16'hFFFF));
		end else begin
			t = (pick == 7) ? longint'(cfg_shadow.start_thr) : longint'(cfg_shadow.cont_thr);
			p.draw = 16'(t - longint'($urandom_range(1)));
		end
		pick = $urandom_range(9);
		if (pick < 6)
			p.jitter = 21'(int'($urandom_range(2 * b)) - int'(b));
		else if (pick < 9)
			p.jitter = 21'(int'($urandom_range(2000000)) - 1000000);
		else
			p.jitter = $urandom_range(1) ? 21'sd1000000 : -21'sd1000000;
		if (!cfg_shadow.enable) begin
			p.arrival = $urandom();
		end else begin
			pick = $urandom_range(19);
			if (pick < 3) begin
				p.arrival = $urandom_range(32'(timeline_us));
			end else begin
				if (pick < 5) begin
					t = longint'({32'b0, cfg_shadow.hold_a_start})
						+ longint'($urandom_range(cfg_shadow.hold_a_len + 2000)) - 1000;
					if (t > timeline_us && t < 64'hF000_0000) timeline_us = t;
				end else if (pick < 7) begin
					t = longint'({32'b0, cfg_shadow.hold_b_start})
						+ longint'($urandom_range(cfg_shadow.hold_b_len + 2000)) - 1000;
					if (t > timeline_us && t < 64'hF000_0000) timeline_us = t;
				end else if (timeline_us < 64'hF000_0000) begin
					timeline_us += longint'($urandom_range(3000000));
				end
				p.arrival = timeline_us[31:0];
			end
		end
		return p;
	endfunction

	task automatic program_random_setting();
		logic [31:0] v;
		logic [31:0] a_start;
		logic [31:0] a_len;
		logic [31:0] b_len;
		write_reg(plc_pkg::REG_ENABLE, ($urandom_range(5) != 0) ? 32'd1 : 32'd0);
		case ($urandom_range(3))
			0: v = 32'd0;
			1: v = 32'd65535;
			2: v = $urandom_range(65535);
			default: v = $urandom_range(12000);
		endcase
		write_reg(plc_pkg::REG_START_THR, v);
		case ($urandom_range(3))
			0: v = 32'd0;
			1: v = 32'd65535;
			2: v = $urandom_range(65535);
			default: v = $urandom_range(65535, 30000);
		endcase
		write_reg(plc_pkg::REG_CONT_THR, v);
		case ($urandom_range(3))
			0: v = 32'd0;
			1: v = 32'd1000000;
			default: v = $urandom_range(1000000);
		endcase
		write_reg(plc_pkg::REG_JITTER_BOUND, v);
		case ($urandom_range(5))
			0: a_start = 32'd0;
			1: a_start = $urandom();
			default: a_start = timeline_us[31:0] + $urandom_range(30000000);
		endcase
		a_len = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(10000000, 1));
		b_len = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(10000000, 1));
		write_reg(plc_pkg::REG_HOLD_A_START, a_start);
		write_reg(plc_pkg::REG_HOLD_A_LEN, a_len);
		case ($urandom_range(2))
			0: v = a_start + a_len - $urandom_range(a_len);
			1: v = a_start - b_len + $urandom_range(a_len);
			default: v = timeline_us[31:0] + $urandom_range(30000000);
		endcase
		write_reg(plc_pkg::REG_HOLD_B_START, v);
		write_reg(plc_pkg::REG_HOLD_B_LEN, b_len);
	endtask

	task automatic test_passthrough();
		write_reg(plc_pkg::REG_START_THR, 32'd65535);
		write_reg(plc_pkg::REG_CONT_THR, 32'd65535);
		write_reg(plc_pkg::REG_JITTER_BOUND, 32'd1000000);
		write_reg(plc_pkg::REG_HOLD_A_START, 32'd0);
		write_reg(plc_pkg::REG_HOLD_A_LEN, 32'hFFFF_FFFF);
		write_reg(plc_pkg::REG_HOLD_B_START, 32'hFFFF_FFFF);
		write_reg(plc_pkg::REG_HOLD_B_LEN, 32'hFFFF_FFFF);
		write_reg(plc_pkg::REG_ENABLE, 32'd0);
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'hFFFF_FFFF, 1'b1, 16'h0000, 1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'h0000_0000, 1'b0, 16'h0000, -1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'h1234_5678, 1'b0, 16'hFFFF, 0));
		wait_drain();
	endtask

	task automatic test_loss_and_resync();
		write_reg(plc_pkg::REG_START_THR, 32'h8000);
		write_reg(plc_pkg::REG_CONT_THR, 32'h8000);
		write_reg(plc_pkg::REG_JITTER_BOUND, 32'd0);
		write_reg(plc_pkg::REG_HOLD_A_LEN, 32'd0);
		write_reg(plc_pkg::REG_HOLD_B_LEN, 32'd0);
		write_reg(plc_pkg::REG_ENABLE, 32'd1);
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd1000, 1'b0, 16'h7FFF, 500));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd2000, 1'b0, 16'h0000, -500));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd3000, 1'b0, 16'h8000, 0));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd4000, 1'b1, 16'hFFFF, 1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'd5000, 1'b1, 16'h7FFF, 0));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'd6000, 1'b0, 16'h0000, 0));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'd7000, 1'b1, 16'h8000, -1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd8000, 1'b0, 16'h7FFF, 0));
		wait_drain();
	endtask

	task automatic test_jitter_and_holds();
		write_reg(plc_pkg::REG_START_THR, 32'd0);
		write_reg(plc_pkg::REG_CONT_THR, 32'd0);
		write_reg(plc_pkg::REG_JITTER_BOUND, 32'd1000);
		write_reg(plc_pkg::REG_HOLD_A_START, 32'd20000);
		write_reg(plc_pkg::REG_HOLD_A_LEN, 32'd1000);
		write_reg(plc_pkg::REG_HOLD_B_START, 32'd21000);
		write_reg(plc_pkg::REG_HOLD_B_LEN, 32'd500);
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd10000, 1'b1, 16'h1234, 5000));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd11500, 1'b1, 16'h0000, -1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'd19500, 1'b0, 16'hFFFF, 700));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'd21200, 1'b0, 16'h4321, 0));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd19999, 1'b1, 16'hFFFF, 0));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd21499, 1'b1, 16'hFFFF, 1));
		wait_drain();
		write_reg(plc_pkg::REG_JITTER_BOUND, 32'd0);
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'd30000, 1'b1, 16'hFFFF, 1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'd30000, 1'b0, 16'hFFFF, -1000000));
		wait_drain();
	endtask

	task automatic test_random_traffic(int src_pct, int snk_pct);
		int s;
		int i;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (s = 0; s < SETS_PER_PHASE; s++) begin
			wait_drain();
			program_random_setting();
			for (i = 0; i < ITEMS_PER_SET; i++) begin
				if (s == 1 && i == ITEMS_PER_SET / 2)
					wait_drain();
				send_pkt(next_random_pkt());
			end
		end
		wait_drain();
	endtask

	task automatic test_release_ceiling();
		write_reg(plc_pkg::REG_START_THR, 32'd0);
		write_reg(plc_pkg::REG_CONT_THR, 32'd0);
		write_reg(plc_pkg::REG_JITTER_BOUND, 32'd1000000);
		write_reg(plc_pkg::REG_HOLD_A_START, 32'hFFFF_FFFF);
		write_reg(plc_pkg::REG_HOLD_A_LEN, 32'hFFFF_FFFF);
		write_reg(plc_pkg::REG_HOLD_B_START, 32'd0);
		write_reg(plc_pkg::REG_HOLD_B_LEN, 32'hFFFF_FFFF);
		write_reg(plc_pkg::REG_ENABLE, 32'd1);
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'h0000_0000, 1'b0, 16'hFFFF, -1000000));
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'h7FFF_FFFF, 1'b0, 16'h0000, 0));
		send_pkt(mk_pkt(plc_pkg::STREAM_VIDEO, 32'h0000_0000, 1'b1, 16'h0000, 0));
		wait_drain();
		write_reg(plc_pkg::REG_ENABLE, 32'd0);
		send_pkt(mk_pkt(plc_pkg::STREAM_AUDIO, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1000000));
		wait_drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_passthrough();
		test_loss_and_resync();
		test_jitter_and_holds();
		test_random_traffic(26, 59);
		test_random_traffic(59, 26);
		test_random_traffic(0, 0);
		test_release_ceiling();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_err == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
